// File: rtl/mfr_pkg.sv
// shared types and constants of the rgb median filter
package mfr_pkg;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned CH_N = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned COORD_W = 10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 2'd2;

  // sort key: top bit marks an empty cell, which sorts above every sample
  localparam logic [PIX_W:0] KEY_EMPTY = {1'b1, {PIX_W{1'b0}}};

  typedef struct packed {
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0]   red_out;
    logic [PIX_W-1:0]   green_out;
    logic [PIX_W-1:0]   blue_out;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               last_of_run;
    logic               end_of_frame;
  } pix_out_t;

  // what one sorting cell hands to its right neighbor
  typedef struct packed {
    logic [CH_N-1:0][PIX_W:0] key;
    logic [CH_N-1:0]          lt;
  } cell_link_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_GATHER = 4'b0010,
    S_FLUSH  = 4'b0100,
    S_OUT    = 4'b1000
  } state_e;

endpackage

// File: rtl/mfr_cell.sv
// one insertion-sort cell holding one sample per color channel
module mfr_cell (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       clr_i,
  input  logic                                       ins_i,
  input  logic [mfr_pkg::CH_N-1:0][mfr_pkg::PIX_W-1:0] pix_i,
  input  mfr_pkg::cell_link_t                        left_i,
  output mfr_pkg::cell_link_t                        link_o
);

  logic [mfr_pkg::CH_N-1:0][mfr_pkg::PIX_W:0] key_q, key_d;
  logic [mfr_pkg::CH_N-1:0]                   lt;

  always_comb begin
    key_d = key_q;
    for (int c = 0; c < mfr_pkg::CH_N; c++) begin
      lt[c] = {1'b0, pix_i[c]} < key_q[c];
      if (clr_i) begin
        key_d[c] = mfr_pkg::KEY_EMPTY;
      end else if (ins_i && lt[c]) begin
        // shift the left value in, or take the new sample at its slot
        key_d[c] = left_i.lt[c] ? left_i.key[c] : {1'b0, pix_i[c]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= {mfr_pkg::CH_N{mfr_pkg::KEY_EMPTY}};
    end else begin
      key_q <= key_d;
    end
  end

  assign link_o.key = key_q;
  assign link_o.lt  = lt;

endmodule

// File: rtl/mfr_sorter.sv
// chain of sorting cells and the median select
module mfr_sorter #(
  parameter int unsigned NCELL = 49
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       clr_i,
  input  logic                                       ins_i,
  input  logic [mfr_pkg::CH_N-1:0][mfr_pkg::PIX_W-1:0] pix_i,
  input  logic [$clog2(NCELL)-1:0]                   mid_i,
  output logic [mfr_pkg::CH_N-1:0][mfr_pkg::PIX_W-1:0] med_o
);

  mfr_pkg::cell_link_t links [NCELL];
  mfr_pkg::cell_link_t head;

  assign head = '0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    mfr_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .clr_i  (clr_i),
      .ins_i  (ins_i),
      .pix_i  (pix_i),
      .left_i ((i == 0) ? head : links[(i == 0) ? 0 : i-1]),
      .link_o (links[i])
    );
  end

  always_comb begin
    for (int c = 0; c < mfr_pkg::CH_N; c++) begin
      med_o[c] = links[mid_i].key[c][mfr_pkg::PIX_W-1:0];
    end
  end

endmodule

// File: rtl/rgb_median_filter_replicate_edge_unit.sv
// top level of the rgb median filter with replicated frame edges
// each window of a run is read tap by tap from the line store into the sorting chain
// throughput: one accepted pixel per cycle when it closes no window, otherwise the input
//   stalls for the whole run, paced by the single read port of the line store and output stalls
// reset: counters return to the frame origin, registers to 512x512 and N=3,
//   the line store holds no defined data until written and needs no clearing pass
module rgb_median_filter_replicate_edge_unit #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned MAX_WINDOW = 7
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // pixel input
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  mfr_pkg::pix_in_t                   in_data_i,
  // filtered output
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output mfr_pkg::pix_out_t                  out_data_o,
  // register write port
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mfr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mfr_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  // sizes derived from the parameters
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned DWW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DHW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned EWW   = (DWW > mfr_pkg::CFG_DATA_W) ? DWW : mfr_pkg::CFG_DATA_W;
  localparam int unsigned EHW   = (DHW > mfr_pkg::CFG_DATA_W) ? DHW : mfr_pkg::CFG_DATA_W;
  localparam int unsigned SW    = $clog2(MAX_WINDOW);
  localparam int unsigned NW    = $clog2(MAX_WINDOW + 1);
  localparam int unsigned NCELL = MAX_WINDOW * MAX_WINDOW;
  localparam int unsigned IW    = $clog2(NCELL);
  localparam int unsigned DEPTH = MAX_WINDOW * MAX_WIDTH;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned LIMW  = ((MAX_WINDOW % 2) == 0) ? MAX_WINDOW - 1 : MAX_WINDOW;

  // configuration registers
  logic [mfr_pkg::CFG_DATA_W-1:0] image_width_q, image_height_q;
  logic [2:0]                     window_size_q;

  // raster position of the next input and its line store row slot
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [SW-1:0] slot_q;

  // run bookkeeping
  mfr_pkg::state_e state_q, state_d;
  logic [RW-1:0] r_run_q, ylo_q, yhi_q, y_q;
  logic [CW-1:0] xlo_q, xhi_q, x_q;
  logic [SW-1:0] slot_run_q;
  logic [NW-1:0] n_q, nwin_q;
  logic [IW-1:0] mid_q;
  logic [SW-1:0] p_q, q_q;
  logic          rd_vld_q;

  // effective frame and window sizes
  logic [EWW-1:0] wv;
  logic [EHW-1:0] hv;
  logic [CW-1:0]  w_m1;
  logic [RW-1:0]  h_m1;
  logic [NW-1:0]  nwin, nn;

  always_comb begin
    wv = EWW'(image_width_q);
    if (wv == '0) wv = EWW'(1);
    if (wv > EWW'(MAX_WIDTH)) wv = EWW'(MAX_WIDTH);
    hv = EHW'(image_height_q);
    if (hv == '0) hv = EHW'(1);
    if (hv > EHW'(MAX_HEIGHT)) hv = EHW'(MAX_HEIGHT);
    w_m1 = CW'(wv - EWW'(1));
    h_m1 = RW'(hv - EHW'(1));
    nwin = NW'(window_size_q);
    if (nwin == '0) nwin = NW'(1);
    if (!nwin[0]) nwin = nwin - NW'(1);
    if (nwin > NW'(LIMW)) nwin = NW'(LIMW);
    nn = nwin >> 1;
  end

  // handshakes
  logic in_acc, out_acc, cfg_wr, cfg_hit;
  assign in_stall_o  = (state_q != mfr_pkg::S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == mfr_pkg::S_OUT);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign cfg_hit     = cfg_wr && (cfg_index_i == mfr_pkg::CFG_IMAGE_WIDTH ||
                                  cfg_index_i == mfr_pkg::CFG_IMAGE_HEIGHT ||
                                  cfg_index_i == mfr_pkg::CFG_WINDOW_SIZE);

  // run bounds of the accepted pixel
  logic          rows_ok, cols_ok, run_start;
  logic [RW-1:0] ylo_n, yhi_n;
  logic [CW-1:0] xlo_n, xhi_n;
  logic [7:0]    cnt_n;

  always_comb begin
    rows_ok = (row_q == h_m1) || (RW'(nn) <= row_q);
    cols_ok = (col_q == w_m1) || (CW'(nn) <= col_q);
    ylo_n   = (RW'(nn) <= row_q) ? row_q - RW'(nn) : '0;
    yhi_n   = (row_q == h_m1) ? row_q : ylo_n;
    xlo_n   = (CW'(nn) <= col_q) ? col_q - CW'(nn) : '0;
    xhi_n   = (col_q == w_m1) ? col_q : xlo_n;
    cnt_n   = 8'(nwin) * 8'(nwin);
    run_start = in_acc && rows_ok && cols_ok;
  end

  // tap address of window position (p, q) around (y, x)
  logic signed [RW+1:0] yv;
  logic signed [CW+1:0] xv;
  logic [RW-1:0]        yy, dy;
  logic [CW-1:0]        xx;
  logic [SW:0]          slot_sum;
  logic [SW-1:0]        tap_slot;
  logic [AW-1:0]        rd_addr, wr_addr;

  always_comb begin
    yv = $signed({2'b00, y_q}) + $signed((RW+2)'(p_q)) - $signed((RW+2)'(n_q));
    xv = $signed({2'b00, x_q}) + $signed((CW+2)'(q_q)) - $signed((CW+2)'(n_q));
    if (yv < 0) yy = '0;
    else if (yv > $signed({2'b00, h_m1})) yy = h_m1;
    else yy = yv[RW-1:0];
    if (xv < 0) xx = '0;
    else if (xv > $signed({2'b00, w_m1})) xx = w_m1;
    else xx = xv[CW-1:0];
    // rows behind the run row sit in earlier slots of the ring
    dy = r_run_q - yy;
    if (slot_run_q >= SW'(dy)) slot_sum = {1'b0, slot_run_q} - (SW+1)'(dy[SW-1:0]);
    else slot_sum = {1'b0, slot_run_q} + (SW+1)'(MAX_WINDOW) - (SW+1)'(dy[SW-1:0]);
    tap_slot = slot_sum[SW-1:0];
    rd_addr  = AW'(tap_slot) * AW'(MAX_WIDTH) + AW'(xx);
    wr_addr  = AW'(slot_q) * AW'(MAX_WIDTH) + AW'(col_q);
  end

  // line store, one write and one registered read per cycle
  logic [3*mfr_pkg::PIX_W-1:0] line_mem [DEPTH];
  logic [3*mfr_pkg::PIX_W-1:0] rd_data_q;
  logic                        issue;

  assign issue = (state_q == mfr_pkg::S_GATHER);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      line_mem[wr_addr] <= in_data_i;
    end
    if (issue) begin
      rd_data_q <= line_mem[rd_addr];
    end
  end

  logic last_tap, last_pix;
  assign last_tap = (p_q == SW'(nwin_q - NW'(1))) && (q_q == SW'(nwin_q - NW'(1)));
  assign last_pix = (x_q == xhi_q) && (y_q == yhi_q);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      mfr_pkg::S_IDLE:   if (run_start) state_d = mfr_pkg::S_GATHER;
      mfr_pkg::S_GATHER: if (last_tap) state_d = mfr_pkg::S_FLUSH;
      mfr_pkg::S_FLUSH:  state_d = mfr_pkg::S_OUT;
      mfr_pkg::S_OUT:    if (out_acc) state_d = last_pix ? mfr_pkg::S_IDLE : mfr_pkg::S_GATHER;
      default:           state_d = mfr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= mfr_pkg::S_IDLE;
      image_width_q  <= mfr_pkg::CFG_DATA_W'(512);
      image_height_q <= mfr_pkg::CFG_DATA_W'(512);
      window_size_q  <= 3'd3;
      col_q          <= '0;
      row_q          <= '0;
      slot_q         <= '0;
      p_q            <= '0;
      q_q            <= '0;
      rd_vld_q       <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      if (cfg_hit) begin
        case (cfg_index_i)
          mfr_pkg::CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i;
          mfr_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_data_i;
          mfr_pkg::CFG_WINDOW_SIZE:  window_size_q  <= cfg_data_i[2:0];
          default: ;
        endcase
        // a write to a known register restarts the frame
        col_q  <= '0;
        row_q  <= '0;
        slot_q <= '0;
      end else if (in_acc) begin
        if (col_q == w_m1) begin
          col_q <= '0;
          if (row_q == h_m1) begin
            row_q  <= '0;
            slot_q <= '0;
          end else begin
            row_q  <= row_q + RW'(1);
            slot_q <= (slot_q == SW'(MAX_WINDOW - 1)) ? '0 : slot_q + SW'(1);
          end
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      // window tap counters
      if (issue) begin
        if (q_q == SW'(nwin_q - NW'(1))) begin
          q_q <= '0;
          p_q <= last_tap ? '0 : p_q + SW'(1);
        end else begin
          q_q <= q_q + SW'(1);
        end
      end
    end
  end

  // run registers carry no reset
  always_ff @(posedge clk_i) begin
    if (run_start) begin
      r_run_q    <= row_q;
      slot_run_q <= slot_q;
      ylo_q      <= ylo_n;
      yhi_q      <= yhi_n;
      xlo_q      <= xlo_n;
      xhi_q      <= xhi_n;
      y_q        <= ylo_n;
      x_q        <= xlo_n;
      n_q        <= nn;
      nwin_q     <= nwin;
      mid_q      <= IW'((cnt_n - 8'd1) >> 1);
    end else if (out_acc && !last_pix) begin
      if (x_q == xhi_q) begin
        x_q <= xlo_q;
        y_q <= y_q + RW'(1);
      end else begin
        x_q <= x_q + CW'(1);
      end
    end
  end

  // sorting chain, cleared before each window
  logic                                       sort_clr;
  logic [mfr_pkg::CH_N-1:0][mfr_pkg::PIX_W-1:0] sort_pix, med;

  assign sort_clr = run_start || (out_acc && !last_pix);
  assign sort_pix = rd_data_q;

  mfr_sorter #(
    .NCELL (NCELL)
  ) u_sorter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (sort_clr),
    .ins_i  (rd_vld_q),
    .pix_i  (sort_pix),
    .mid_i  (mid_q),
    .med_o  (med)
  );

  // result beat, stable while in the output state
  always_comb begin
    out_data_o.red_out      = med[2];
    out_data_o.green_out    = med[1];
    out_data_o.blue_out     = med[0];
    out_data_o.out_row      = mfr_pkg::COORD_W'(y_q);
    out_data_o.out_col      = mfr_pkg::COORD_W'(x_q);
    out_data_o.last_of_run  = last_pix;
    out_data_o.end_of_frame = (y_q == h_m1) && (x_q == w_m1);
  end

  // checks
  a_out_blocks_in : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open while a result waits");

  a_acc_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !out_valid_o) else $error("result without gathering");

  a_read_in_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == mfr_pkg::S_GATHER || state_q == mfr_pkg::S_FLUSH))
    else $error("tap data outside a window gather");

  a_cfg_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_hit && !in_acc) |=> (row_q == '0 && col_q == '0 && slot_q == '0))
    else $error("register write did not restart the frame");

endmodule

// File: tb/sv/tb.sv
// testbench for the rgb median filter with replicated frame edges
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE_ROWS = 7;
  localparam int unsigned LINE_COLS = 1024;
  localparam int unsigned DIM_MAX   = 1024;
  localparam int unsigned WIN_MAX   = 7;
  // one result at the largest window, with margin
  localparam int unsigned SETTLE    = 64;
  localparam int unsigned IDLE_LIMIT = 4000;

  // windowed median predictor plus queue of expected filtered pixels
  class median_scoreboard;
    logic [23:0]  line_mem [LINE_ROWS*LINE_COLS];
    int unsigned  row_pos, col_pos;
    logic [10:0]  width_reg, height_reg;
    logic [2:0]   win_reg;
    mfr_pkg::pix_out_t expected_q[$];
    int unsigned  mismatches;

    function new();
      foreach (line_mem[i]) line_mem[i] = '0;
      row_pos = 0;
      col_pos = 0;
      width_reg = 11'd512;
      height_reg = 11'd512;
      win_reg = 3'd3;
      mismatches = 0;
    endfunction

    function int unsigned dim_of(logic [10:0] v);
      int unsigned d;
      d = v;
      if (d == 0) d = 1;
      if (d > DIM_MAX) d = DIM_MAX;
      return d;
    endfunction

    function int unsigned win_of();
      int unsigned s;
      s = win_reg;
      if (s == 0) s = 1;
      if ((s & 1) == 0) s = s - 1;
      if (s > WIN_MAX) s = WIN_MAX;
      return s;
    endfunction

    // any write to a known register restarts the frame
    function void write_reg(logic [mfr_pkg::CFG_IDX_W-1:0] idx,
                            logic [mfr_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        mfr_pkg::CFG_IMAGE_WIDTH: width_reg = data;
        mfr_pkg::CFG_IMAGE_HEIGHT: height_reg = data;
        mfr_pkg::CFG_WINDOW_SIZE: win_reg = data[2:0];
        default: return;
      endcase
      row_pos = 0;
      col_pos = 0;
    endfunction

    function logic [7:0] median_of(logic [7:0] vals[$]);
      logic [7:0] t;
      int j;
      for (int i = 1; i < vals.size(); i++) begin
        t = vals[i];
        j = i;
        while (j > 0 && vals[j-1] > t) begin
          vals[j] = vals[j-1];
          j--;
        end
        vals[j] = t;
      end
      return vals[(vals.size() - 1) / 2];
    endfunction

    function int unsigned clamp(int v, int unsigned size);
      if (v < 0) return 0;
      if (v >= int'(size)) return size - 1;
      return v;
    endfunction

    // store the beat and queue every window it closes
    function void note_pixel(mfr_pkg::pix_in_t px);
      int unsigned w, h, nw, n, r, c, ylo, yhi, xlo, xhi, yy, xx;
      logic [23:0] tap;
      logic [7:0] rv[$], gv[$], bv[$];
      mfr_pkg::pix_out_t res;
      bit rows_ok, cols_ok;
      w = dim_of(width_reg);
      h = dim_of(height_reg);
      nw = win_of();
      n = (nw - 1) / 2;
      r = row_pos;
      c = col_pos;
      if (r >= h || c >= w) begin
        r = 0;
        c = 0;
      end
      line_mem[(r % LINE_ROWS) * LINE_COLS + c] = {px.red_in, px.green_in, px.blue_in};
      rows_ok = (r == h - 1) || (r >= n);
      cols_ok = (c == w - 1) || (c >= n);
      if (rows_ok && cols_ok) begin
        ylo = (r >= n) ? r - n : 0;
        yhi = (r == h - 1) ? r : ylo;
        xlo = (c >= n) ? c - n : 0;
        xhi = (c == w - 1) ? c : xlo;
        for (int unsigned y = ylo; y <= yhi; y++) begin
          for (int unsigned x = xlo; x <= xhi; x++) begin
            rv.delete();
            gv.delete();
            bv.delete();
            for (int p = 0; p < int'(nw); p++) begin
              yy = clamp(int'(y) + p - int'(n), h);
              for (int q = 0; q < int'(nw); q++) begin
                xx = clamp(int'(x) + q - int'(n), w);
                tap = line_mem[(yy % LINE_ROWS) * LINE_COLS + xx];
                rv.push_back(tap[23:16]);
                gv.push_back(tap[15:8]);
                bv.push_back(tap[7:0]);
              end
            end
            res.red_out = median_of(rv);
            res.green_out = median_of(gv);
            res.blue_out = median_of(bv);
            res.out_row = y[mfr_pkg::COORD_W-1:0];
            res.out_col = x[mfr_pkg::COORD_W-1:0];
            res.last_of_run = (y == yhi && x == xhi);
            res.end_of_frame = (y == h - 1 && x == w - 1);
            expected_q.push_back(res);
          end
        end
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      row_pos = r;
      col_pos = c;
    endfunction

    function void check_result(mfr_pkg::pix_out_t got);
      mfr_pkg::pix_out_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      want = expected_q.pop_front();
      if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
          got.blue_out !== want.blue_out || got.out_row !== want.out_row ||
          got.out_col !== want.out_col || got.last_of_run !== want.last_of_run ||
          got.end_of_frame !== want.end_of_frame) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o;
  mfr_pkg::pix_in_t in_data_i;
  logic out_valid_o, out_stall_i;
  mfr_pkg::pix_out_t out_data_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [mfr_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [mfr_pkg::CFG_DATA_W-1:0] cfg_data_i;

  median_scoreboard sb;
  int unsigned idle_cycles;
  int unsigned stall_left;
  int unsigned cycle_count;
  int unsigned rand_items;

  rgb_median_filter_replicate_edge_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // monitor: every accepted beat goes to the scoreboard, watchdog on no progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_pixel(in_data_i);
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if ((in_valid_i && !in_stall_o) || (cfg_valid_i && cfg_ready_o) ||
          (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // receiver backpressure: quiet stretches alternate with busy ones
  always @(negedge clk_i) begin
    cycle_count++;
    if (stall_left > 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else begin
      out_stall_i = 1'b0;
      if ((cycle_count / 300) % 3 != 0) begin
        if ($urandom_range(0, 39) == 0) stall_left = $urandom_range(20, 40);
        else if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 3);
      end
    end
  end

  function int unsigned pick_gap();
    if ($urandom_range(0, 2) != 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 30);
    return $urandom_range(1, 3);
  endfunction

  // called at a falling edge, returns at a falling edge after acceptance
  task automatic send_pixel(mfr_pkg::pix_in_t px);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = px;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    // no-result beats may still be in flight
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [mfr_pkg::CFG_IDX_W-1:0] idx,
                           logic [mfr_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned ws);
    write_reg(mfr_pkg::CFG_IMAGE_WIDTH, w[mfr_pkg::CFG_DATA_W-1:0]);
    write_reg(mfr_pkg::CFG_IMAGE_HEIGHT, h[mfr_pkg::CFG_DATA_W-1:0]);
    write_reg(mfr_pkg::CFG_WINDOW_SIZE, ws[mfr_pkg::CFG_DATA_W-1:0]);
  endtask

  task automatic send_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_pixel(mfr_pkg::pix_in_t'(24'($urandom)));
  endtask

  initial begin
    int unsigned w, h, cnt;
    mfr_pkg::pix_in_t px;
    sb = new();
    idle_cycles = 0;
    stall_left = 0;
    cycle_count = 0;
    rand_items = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = mfr_pkg::CFG_IMAGE_WIDTH;
    cfg_data_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset geometry: first row of a 512x512 frame closes no window
    send_pixel('{8'hFF, 8'h00, 8'hFF});
    send_pixel('{8'h00, 8'hFF, 8'h00});
    send_pixel('{8'hFF, 8'hFF, 8'hFF});
    drain();

    // full 3x3 frame with extreme samples
    set_frame(3, 3, 3);
    for (int i = 0; i < 9; i++) begin
      px = (i % 2) ? mfr_pkg::pix_in_t'{8'hFF, 8'h00, 8'hFF} :
                     mfr_pkg::pix_in_t'{8'h00, 8'hFF, 8'h00};
      send_pixel(px);
    end
    drain();

    // zero sizes act as one, largest window on a single pixel frame
    set_frame(0, 0, 7);
    send_pixel('{8'h12, 8'h34, 8'h56});
    send_pixel('{8'hFF, 8'hFF, 8'hFF});
    drain();

    // oversize width saturates, single row, window 7
    set_frame(2047, 1, 7);
    send_random(6);
    drain();

    // single column, maximum height, even window rounds down
    set_frame(1, 1024, 6);
    send_random(6);
    drain();

    // unknown register index is ignored and does not restart the frame
    set_frame(4, 2, 0);
    send_random(3);
    drain();
    write_reg(2'd3, 11'h7FF);
    send_random(5);
    drain();

    // random frames, mostly complete ones, some cut short
    while (rand_items < 60) begin
      w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 9);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      set_frame(w, h, $urandom_range(0, 7));
      cnt = (w == 0 ? 1 : w) * (h == 0 ? 1 : h) * $urandom_range(1, 2);
      if ($urandom_range(0, 4) == 0) cnt = $urandom_range(1, cnt);
      if (cnt > 40) cnt = 40;
      if ($urandom_range(0, 3) == 0) begin
        // sender holds off mid frame until the block has caught up
        send_random(cnt / 2);
        drain();
        send_random(cnt - cnt / 2);
      end else begin
        send_random(cnt);
      end
      rand_items += cnt;
      drain();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
